### rtl/stn_pkg.sv
// Shared types and constants for the SQL text template normalizer.
// No dependencies; imported by sql_text_template_normalizer and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package stn_pkg;

	// Width of the character limit register and of the character counter.
	localparam int unsigned LimitWidth = 10;

	// Default template buffer size; the effective limit is at most one less.
	localparam int unsigned DefaultTemplateBuffer = 1024;

	// Value of the limit register after reset.
	localparam logic [LimitWidth-1:0] MaxCharsReset = 10'd1023;

	// Characters with a special role in the template.
	localparam logic [7:0] ChQuote = 8'h27;
	localparam logic [7:0] ChQmark = 8'h3F;
	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChEnd   = 8'h00;

	// Depth of the result queue: one beat left over plus the two that one byte can make.
	localparam int unsigned QueueDepth = 3;

	// One result beat as it sits in the queue.
	typedef struct packed {
		logic [7:0] out_char;
		logic       char_valid;
		logic       end_mark;
		logic       template_empty;
	} result_t;

endpackage

`default_nettype wire

### rtl/sql_text_template_normalizer.sv
// Top level of the SQL text template normalizer; depends on stn_pkg.
// A result beat is registered into the queue when its input is taken and offered from the head.
// Throughput: one input byte per cycle unless stalled; a byte that releases a held space
// makes two beats, which the three-entry result queue absorbs. The input side stalls
// only when the result queue could not take two more beats.
// Reset (arst_n low, asynchronous) clears the scan state and queue and sets max_chars to 1023.
`timescale 1ns / 1ps
`default_nettype none

module sql_text_template_normalizer #(
	parameter int unsigned TEMPLATE_BUFFER = stn_pkg::DefaultTemplateBuffer
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// Configuration: max_chars is written when cfg_wr_en is high.
	input  wire logic                               cfg_wr_en,
	input  wire logic [stn_pkg::LimitWidth-1:0]     cfg_wr_data,
	// Input stream. s_tdata: [7:0] text_byte.
	input  wire logic                               s_tvalid,
	output      logic                               s_tready,
	input  wire logic [7:0]                         s_tdata,
	// Output stream. m_tdata: [7:0] out_char. m_tuser: [0] char_valid, [1] template_empty.
	// m_tlast carries end_mark.
	output      logic                               m_tvalid,
	input  wire logic                               m_tready,
	output      logic [7:0]                         m_tdata,
	output      logic [1:0]                         m_tuser,
	output      logic                               m_tlast
);

	import stn_pkg::*;

	// The buffer keeps one slot in reserve, so the usable limit is one below its size.
	localparam logic [LimitWidth-1:0] BufCap = LimitWidth'(TEMPLATE_BUFFER - 1);

	// Configuration register.
	logic [LimitWidth-1:0] max_chars_q;

	// Scan state for the statement in progress.
	logic                  inside_quote_q;
	logic                  inside_number_q;
	logic                  space_pending_q;
	logic [LimitWidth-1:0] chars_counted_q;

	// Result queue: entry 0 is the head shown on the master side.
	result_t   queue_q [QueueDepth];
	logic [1:0] count_q;

	// Per-byte decision.
	logic                  in_fire;
	logic                  out_fire;
	logic [LimitWidth-1:0] eff_limit;
	logic [7:0]            in_byte;
	logic                  is_ws;
	logic                  is_digit;
	logic                  is_lower;
	logic                  do_emit;
	logic [7:0]            emit_ch;
	logic                  do_end;
	logic                  nx_quote;
	logic                  nx_number;
	logic                  nx_space;
	logic [LimitWidth-1:0] nx_count;
	result_t               res0;
	result_t               res1;
	logic [1:0]            n_res;
	logic [1:0]            count_after_pop;

	assign in_byte   = s_tdata;
	assign eff_limit = (max_chars_q < BufCap) ? max_chars_q : BufCap;
	assign is_ws     = (in_byte == ChSpace) || (in_byte >= 8'h09 && in_byte <= 8'h0D);
	assign is_digit  = (in_byte >= 8'h30) && (in_byte <= 8'h39);
	assign is_lower  = (in_byte >= 8'h61) && (in_byte <= 8'h7A);

	// Walk the special cases in priority order: end byte, limit, quote, quoted body,
	// digits, whitespace, and finally ordinary characters.
	always_comb begin
		do_emit   = 1'b0;
		do_end    = 1'b0;
		emit_ch   = ChQmark;
		nx_quote  = inside_quote_q;
		nx_number = inside_number_q;
		nx_space  = space_pending_q;
		nx_count  = chars_counted_q;
		if (in_byte == ChEnd) begin
			do_end    = 1'b1;
			nx_quote  = 1'b0;
			nx_number = 1'b0;
			nx_space  = 1'b0;
			nx_count  = '0;
		end else if (chars_counted_q >= eff_limit) begin
			// At the limit every byte is dropped until the end byte.
		end else if (in_byte == ChQuote) begin
			nx_number = 1'b0;
			if (inside_quote_q) begin
				nx_quote = 1'b0;
			end else begin
				nx_quote = 1'b1;
				do_emit  = 1'b1;
			end
		end else if (inside_quote_q) begin
			// The body of a quoted literal is dropped.
		end else if (is_digit) begin
			if (!inside_number_q) begin
				nx_number = 1'b1;
				do_emit   = 1'b1;
			end
		end else begin
			nx_number = 1'b0;
			if (is_ws) begin
				// A held space counts toward the limit when it is taken.
				if (!space_pending_q && chars_counted_q != '0) begin
					nx_space = 1'b1;
					nx_count = chars_counted_q + 1'b1;
				end
			end else begin
				do_emit = 1'b1;
				emit_ch = is_lower ? (in_byte - 8'h20) : in_byte;
			end
		end

		// Build up to two result beats; a held space goes out ahead of the character.
		res0  = '{out_char: ChSpace, char_valid: 1'b1, end_mark: 1'b0, template_empty: 1'b0};
		res1  = '{out_char: emit_ch, char_valid: 1'b1, end_mark: 1'b0, template_empty: 1'b0};
		n_res = 2'd0;
		if (do_end) begin
			res0  = '{out_char: ChEnd, char_valid: 1'b0, end_mark: 1'b1,
				template_empty: (chars_counted_q == '0)};
			n_res = 2'd1;
		end else if (do_emit) begin
			nx_count = chars_counted_q + 1'b1;
			if (space_pending_q) begin
				nx_space = 1'b0;
				n_res    = 2'd2;
			end else begin
				res0  = res1;
				n_res = 2'd1;
			end
		end
	end

	// Handshakes. The queue must have room for two beats after this cycle's pop.
	assign out_fire        = m_tvalid && m_tready;
	assign count_after_pop = count_q - {1'b0, out_fire};
	assign s_tready        = (count_after_pop <= 2'd1);
	assign in_fire         = s_tvalid && s_tready;

	assign m_tvalid = (count_q != 2'd0);
	assign m_tdata  = queue_q[0].out_char;
	assign m_tuser  = {queue_q[0].template_empty, queue_q[0].char_valid};
	assign m_tlast  = queue_q[0].end_mark;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_chars_q <= MaxCharsReset;
		end else if (cfg_wr_en) begin
			max_chars_q <= cfg_wr_data;
		end
	end

	// Scan state advances only on an accepted input beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_quote_q  <= 1'b0;
			inside_number_q <= 1'b0;
			space_pending_q <= 1'b0;
			chars_counted_q <= '0;
		end else if (in_fire) begin
			inside_quote_q  <= nx_quote;
			inside_number_q <= nx_number;
			space_pending_q <= nx_space;
			chars_counted_q <= nx_count;
		end
	end

	// Queue occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= count_after_pop + (in_fire ? n_res : 2'd0);
		end
	end

	// Queue payload: shift down on a pop, then append the new beats behind what remains.
	always_ff @(posedge clk) begin
		for (int i = 0; i < QueueDepth; i++) begin
			if (in_fire && n_res != 2'd0 && 2'(i) == count_after_pop) begin
				queue_q[i] <= res0;
			end else if (in_fire && n_res == 2'd2 && 2'(i) == count_after_pop + 2'd1) begin
				queue_q[i] <= res1;
			end else if (out_fire && i < QueueDepth - 1) begin
				queue_q[i] <= queue_q[(i < QueueDepth - 1) ? i + 1 : i];
			end
		end
	end

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for sql_text_template_normalizer: directed and random statements,
// predicted in place and checked beat by beat. Depends on stn_pkg and the normalizer RTL.
`timescale 1ns / 1ps
`default_nettype none

module testbench;

	import stn_pkg::*;

	// The effective limit can never exceed one less than the template buffer.
	localparam logic [LimitWidth-1:0] BufferCap = LimitWidth'(DefaultTemplateBuffer - 1);
	localparam int unsigned HoldOffCycles = 400;
	localparam int unsigned HoldOffAfter = 60;
	localparam int unsigned IdlePercent = 26;
	localparam int unsigned PhaseBytes = 65;

	// Every input is at a known value from time zero.
	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [LimitWidth-1:0] cfg_wr_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata = 8'h00;     // [7:0] text_byte
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [7:0]            m_tdata;             // [7:0] out_char
	logic [1:0]            m_tuser;             // [0] char_valid, [1] template_empty
	logic                  m_tlast;             // end_mark

	// Bytes waiting for the driver, and template beats waiting for the monitor.
	logic [7:0] pending_bytes [$];
	result_t    template_q [$];

	// Scan state and limit register as the normalizer should hold them.
	logic                  in_quote = 1'b0;
	logic                  in_number = 1'b0;
	logic                  space_held = 1'b0;
	logic [LimitWidth-1:0] chars_out = '0;
	logic [LimitWidth-1:0] limit_reg = MaxCharsReset;

	// While set, neither side inserts random idle cycles.
	logic steady = 1'b0;

	int mismatches = 0;
	int beats_seen = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	// A short statement that touches every byte class: an empty statement, a leading
	// blank, mixed case, digits right after a letter, a closed literal, a run of the
	// whitespace bytes 0A to 0D, high bytes, and an unclosed literal cut by the end byte.
	logic [7:0] directed_text [21] = '{
		8'h00, 8'h20, "s", "E", 8'h09, "z", "1", "2", ChQuote, "q", ChQuote,
		8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'hFF, 8'h80, "9", ChQuote, "x", ChEnd
	};

	// Limit settings, one per random phase; the extremes come first.
	logic [LimitWidth-1:0] phase_limits [7] = '{
		10'd1023, 10'd0, 10'd1, 10'd7, 10'd40, 10'd1023, 10'd600
	};

	sql_text_template_normalizer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

	always #10 clk = ~clk;

	// Queue one template character, releasing a held space in front of it.
	function void emit_char(input logic [7:0] ch);
		if (space_held) begin
			template_q.push_back('{out_char: ChSpace, char_valid: 1'b1, end_mark: 1'b0,
				template_empty: 1'b0});
			space_held = 1'b0;
		end
		template_q.push_back('{out_char: ch, char_valid: 1'b1, end_mark: 1'b0,
			template_empty: 1'b0});
		chars_out = chars_out + 1'b1;
	endfunction

	// Advance the scan state by one accepted byte and queue the beats it causes.
	function void normalize_byte(input logic [7:0] b);
		logic [LimitWidth-1:0] lim;
		lim = (limit_reg < BufferCap) ? limit_reg : BufferCap;
		if (b == ChEnd) begin
			// The end byte always yields the end beat, even past the limit.
			template_q.push_back('{out_char: ChEnd, char_valid: 1'b0, end_mark: 1'b1,
				template_empty: (chars_out == '0)});
			in_quote = 1'b0;
			in_number = 1'b0;
			space_held = 1'b0;
			chars_out = '0;
			return;
		end
		// Once the limit is reached everything but the end byte is dropped.
		if (chars_out >= lim)
			return;
		if (b == ChQuote) begin
			in_number = 1'b0;
			if (in_quote) begin
				in_quote = 1'b0;
				return;
			end
			in_quote = 1'b1;
			emit_char(ChQmark);
			return;
		end
		if (in_quote)
			return;
		if (b >= "0" && b <= "9") begin
			// Only the first digit of a run shows up, as a question mark.
			if (!in_number) begin
				in_number = 1'b1;
				emit_char(ChQmark);
			end
			return;
		end
		in_number = 1'b0;
		if (b == ChSpace || (b >= 8'h09 && b <= 8'h0D)) begin
			// A held space counts toward the limit as soon as it is taken.
			if (!space_held && chars_out != '0) begin
				space_held = 1'b1;
				chars_out = chars_out + 1'b1;
			end
			return;
		end
		if (b >= "a" && b <= "z")
			emit_char(b - 8'h20);
		else
			emit_char(b);
	endfunction

	// Driver: offers pending bytes, holds a beat until it is taken, and feeds
	// every accepted byte to the predictor.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'h00;
		end else begin
			if (s_tvalid && s_tready)
				normalize_byte(s_tdata);
			if (!s_tvalid || s_tready) begin
				if (pending_bytes.size() != 0 &&
						(steady || $urandom_range(0, 99) >= IdlePercent)) begin
					s_tvalid <= 1'b1;
					s_tdata <= pending_bytes.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Hold-off counter: once HoldOffAfter beats have been seen, the receiver stops taking results
	// until the counter runs out, so that the result queue fills and the input side has to stall.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_done <= 1'b0;
			hold_left <= 0;
		end else if (!hold_done && beats_seen >= HoldOffAfter) begin
			hold_done <= 1'b1;
			hold_left <= HoldOffCycles;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Monitor: checks every accepted template beat against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				beats_seen++;
				if (template_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected beat: char=%h user=%b last=%b",
							m_tdata, m_tuser, m_tlast);
				end else begin
					want = template_q.pop_front();
					if (m_tdata !== want.out_char || m_tuser[0] !== want.char_valid ||
							m_tuser[1] !== want.template_empty || m_tlast !== want.end_mark) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: want %h %b %b %b, got %h %b %b %b",
								want.out_char, want.char_valid, want.template_empty,
								want.end_mark, m_tdata, m_tuser[0], m_tuser[1], m_tlast);
					end
				end
			end
			if (hold_left > 0)
				m_tready <= 1'b0;
			else
				m_tready <= steady || $urandom_range(0, 99) >= IdlePercent;
		end
	end

	// Wait until every byte is taken and every beat checked, then let the pipeline settle.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_bytes.size() != 0 || s_tvalid || template_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Write the limit register; only called while the block is idle.
	task automatic write_limit(input logic [LimitWidth-1:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		limit_reg = value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Build one statement from SQL-like tokens with random content, plus some noise,
	// and close it with the end byte. Returns the number of bytes queued.
	task automatic queue_statement(output int count);
		int tokens;
		int len;
		logic [7:0] b;
		count = 0;
		tokens = $urandom_range(1, 8);
		repeat (tokens) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					len = $urandom_range(1, 6);
					repeat (len) begin
						b = $urandom_range(0, 1) ? "a" : "A";
						pending_bytes.push_back(b + 8'($urandom_range(0, 25)));
						count++;
					end
				end
				3: begin
					len = $urandom_range(1, 4);
					repeat (len) begin
						pending_bytes.push_back("0" + 8'($urandom_range(0, 9)));
						count++;
					end
				end
				4: begin
					// A literal with arbitrary content; most of them get closed.
					pending_bytes.push_back(ChQuote);
					count++;
					len = $urandom_range(0, 4);
					repeat (len) begin
						pending_bytes.push_back(8'($urandom_range(1, 255)));
						count++;
					end
					if ($urandom_range(0, 9) != 0) begin
						pending_bytes.push_back(ChQuote);
						count++;
					end
				end
				5, 6: begin
					len = $urandom_range(1, 3);
					repeat (len) begin
						b = $urandom_range(0, 1) ? ChSpace : 8'($urandom_range(9, 13));
						pending_bytes.push_back(b);
						count++;
					end
				end
				7: begin
					case ($urandom_range(0, 5))
						0: b = ",";
						1: b = "=";
						2: b = "(";
						3: b = ")";
						4: b = "*";
						default: b = ";";
					endcase
					pending_bytes.push_back(b);
					count++;
				end
				8: begin
					pending_bytes.push_back(8'($urandom_range(1, 255)));
					count++;
				end
				default: begin
					pending_bytes.push_back(8'($urandom_range(128, 255)));
					count++;
				end
			endcase
		end
		pending_bytes.push_back(ChEnd);
		count++;
	endtask

	// Stimulus: reset, directed bytes at the reset limit, then one random phase per
	// limit setting with the block drained before each register write.
	initial begin
		int queued;
		int stmt_len;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_text[i])
			pending_bytes.push_back(directed_text[i]);
		wait_drained();

		foreach (phase_limits[p]) begin
			write_limit(phase_limits[p]);
			// One whole phase runs with no idling on either side.
			steady = (p == 4);
			queued = 0;
			while (queued < PhaseBytes) begin
				queue_statement(stmt_len);
				queued += stmt_len;
			end
			wait_drained();
		end
		steady = 1'b0;

		repeat (8) @(posedge clk);
		if (mismatches == 0 && template_q.size() == 0)
			$display("sql_text_template_normalizer test passed");
		else
			$display("sql_text_template_normalizer test failed");
		$finish;
	end

	// Ends the run as failed if the stimulus has not finished by this bound.
	initial begin
		#2000000;
		$display("sql_text_template_normalizer test failed");
		$finish;
	end

endmodule

`default_nettype wire
